@@ src/pgs_pkg.sv @@
`default_nettype none

package pgs_pkg;

    // Fixed field widths.
    localparam int TICK_W    = 12;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT     = 3'd4;

    // Reset values; lengths and start y in whole units before fraction scaling.
    localparam int RST_RADIUS_UNITS  = 10;
    localparam int RST_STEP_UNITS    = 20;
    localparam int RST_START_Y_UNITS = 50;
    localparam logic [TICK_W-1:0] RST_TICK_LIMIT = 12'd13;

    // Tick counter ceiling.
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

endpackage

`default_nettype wire

@@ src/pgs_isqrt.sv @@
`default_nettype none

// Digit-by-digit integer square root, one result bit per cycle.
module pgs_isqrt #(
    parameter int RW = 50
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RW-1:0]     i_radicand,
    output logic                   o_done,
    output logic [RW/2-1:0]        o_root
);

    logic [RW-1:0] r_v;
    logic [RW-1:0] r_r;
    logic [RW-1:0] r_bit;
    logic          r_busy;
    logic          r_done;
    logic [RW:0]   sum;
    logic          take;

    // Trial subtraction of the current root estimate plus the bit under test.
    assign sum  = {1'b0, r_r} + {1'b0, r_bit};
    assign take = ({1'b0, r_v} >= sum);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder, root and bit position.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_radicand;
            r_r   <= '0;
            r_bit <= {2'b01, {(RW-2){1'b0}}};
        end else if (r_busy) begin
            if (take) begin
                r_v <= r_v - sum[RW-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[RW/2-1:0];

endmodule

`default_nettype wire

@@ src/pgs_udiv.sv @@
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
// The quotient must fit in QW bits, so the upper part of the numerator is
// below the divisor.
module pgs_udiv #(
    parameter int NW = 48,
    parameter int DW = 25,
    parameter int QW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [QW-1:0]      o_quo
);

    localparam int CW = $clog2(QW);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          fits;

    // Shift the next numerator bit into the partial remainder and compare.
    assign trial = {r_rem, r_quo[QW-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder and quotient share the shift path.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num[NW-1:QW]);
            r_quo <= i_num[QW-1:0];
            r_den <= i_den;
            r_cnt <= CW'(QW - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DW'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DW-1:0];
            end
            r_quo <= {r_quo[QW-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ src/pursuit_guidance_step.sv @@
`default_nettype none

// Per item: squaring, COORD_WIDTH+1 root steps and COORD_WIDTH divide steps per axis,
// plus control. A capture skips the moves; an item after the end skips the arithmetic.
// The input is not ready while an item is in progress or its result waits. The root
// and divide units are iterative; the divider is shared by both axes.
// Reset is synchronous, active low; configuration registers and pursuer position
// take their defaults.
module pursuit_guidance_step #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pgs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]            i_cfg_data,
    // Input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]     i_target_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_target_y,
    // Output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [COORD_WIDTH-1:0]          o_pursuer_x,
    output logic signed [COORD_WIDTH-1:0]          o_pursuer_y,
    output logic [COORD_WIDTH-1:0]                 o_separation,
    output logic [pgs_pkg::TICK_W-1:0]             o_tick_index,
    output logic                                   o_caught,
    output logic                                   o_escaped,
    output logic                                   o_done_res
);

    import pgs_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int LW = COORD_WIDTH - 1;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH;
    localparam int RW = 2 * COORD_WIDTH + 2;

    localparam logic [LW-1:0] RST_RADIUS  = LW'(RST_RADIUS_UNITS << FRAC_BITS);
    localparam logic [LW-1:0] RST_STEP    = LW'(RST_STEP_UNITS << FRAC_BITS);
    localparam logic [CW-1:0] RST_START_Y = CW'(RST_START_Y_UNITS << FRAC_BITS);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SQX     = 4'd1;
    localparam logic [3:0] ST_SQY     = 4'd2;
    localparam logic [3:0] ST_RSTART  = 4'd3;
    localparam logic [3:0] ST_RWAIT   = 4'd4;
    localparam logic [3:0] ST_DECIDE  = 4'd5;
    localparam logic [3:0] ST_DXSTART = 4'd6;
    localparam logic [3:0] ST_DXWAIT  = 4'd7;
    localparam logic [3:0] ST_DYSTART = 4'd8;
    localparam logic [3:0] ST_DYWAIT  = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    // Configuration registers.
    logic [LW-1:0]     r_radius;
    logic [LW-1:0]     r_step;
    logic [TICK_W-1:0] r_tick_limit;

    // Pursuit state.
    logic [CW-1:0]     r_pos_x;
    logic [CW-1:0]     r_pos_y;
    logic [TICK_W-1:0] r_tick;
    logic              r_finished;

    // Per-item working registers.
    logic [3:0]        r_state;
    logic signed [CW:0] r_dx;
    logic signed [CW:0] r_dy;
    logic [PW-1:0]     r_acc;
    logic [PW-1:0]     r_prod;
    logic [DW-1:0]     r_dist;
    logic              r_caught;
    logic              r_escaped;
    logic              r_done_item;

    // Output register.
    logic              r_ovalid;
    logic [CW-1:0]     r_out_x;
    logic [CW-1:0]     r_out_y;
    logic [CW-1:0]     r_out_sep;
    logic [TICK_W-1:0] r_out_idx;
    logic              r_out_caught;
    logic              r_out_escaped;
    logic              r_out_done;

    // Combinational helpers.
    logic [CW-1:0]     ax;
    logic [CW-1:0]     ay;
    logic              halve;
    logic [CW-1:0]     ax_s;
    logic [CW-1:0]     ay_s;
    logic [CW-1:0]     mul_a;
    logic [CW-1:0]     mul_b;
    logic [PW-1:0]     mul_p;
    logic [RW-1:0]     radicand;
    logic [DW-1:0]     root;
    logic              root_done;
    logic              root_start;
    logic              div_start;
    logic [PW-1:0]     div_num;
    logic [CW-1:0]     quo;
    logic              div_done;
    logic [DW-1:0]     dist_now;
    logic [CW-1:0]     sep_now;
    logic [TICK_W-1:0] lim;
    logic [TICK_W:0]   idx_next;
    logic              fresh;
    logic              out_free;
    logic              in_take;

    // Saturating position update by a signed step of magnitude q.
    function automatic logic [CW-1:0] move_sat(input logic [CW-1:0] p,
                                               input logic neg,
                                               input logic [CW-1:0] q);
        logic signed [CW+1:0] s;
        logic signed [CW+1:0] ps;
        logic signed [CW+1:0] qs;
        ps = {{2{p[CW-1]}}, p};
        qs = {2'b00, q};
        s  = neg ? (ps - qs) : (ps + qs);
        if ((s[CW+1:CW-1] == 3'b000) || (s[CW+1:CW-1] == 3'b111)) begin
            move_sat = s[CW-1:0];
        end else if (s[CW+1]) begin
            move_sat = {1'b1, {(CW-1){1'b0}}};
        end else begin
            move_sat = {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    // Axis magnitudes; very large differences are halved before the root.
    assign ax    = r_dx[CW] ? CW'(-r_dx) : r_dx[CW-1:0];
    assign ay    = r_dy[CW] ? CW'(-r_dy) : r_dy[CW-1:0];
    assign halve = ((ax >> 31) != '0) || ((ay >> 31) != '0);
    assign ax_s  = halve ? (ax >> 1) : ax;
    assign ay_s  = halve ? (ay >> 1) : ay;

    // Shared multiplier operand selection.
    always_comb begin
        case (r_state)
            ST_SQX: begin
                mul_a = ax_s;
                mul_b = ax_s;
            end
            ST_SQY: begin
                mul_a = ay_s;
                mul_b = ay_s;
            end
            ST_DECIDE: begin
                mul_a = {1'b0, r_step};
                mul_b = ax;
            end
            default: begin
                mul_a = {1'b0, r_step};
                mul_b = ay;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Root and divider launch.
    assign radicand   = {2'b00, r_acc} + {2'b00, r_prod};
    assign root_start = (r_state == ST_RSTART);
    assign div_start  = (r_state == ST_DXSTART) || (r_state == ST_DYSTART);
    assign div_num    = r_prod + {{CW{1'b0}}, r_dist[CW:1]};
    assign dist_now   = halve ? DW'({root, 1'b0}) : root;
    assign sep_now    = r_dist[CW] ? '1 : r_dist[CW-1:0];

    // Tick bookkeeping.
    assign lim      = (r_tick_limit == '0) ? TICK_W'(1) : r_tick_limit;
    assign idx_next = {1'b0, r_tick} + 1'b1;
    assign fresh    = (r_tick == '0) && !r_finished;

    // Handshakes.
    assign out_free    = !r_ovalid || i_out_ready;
    assign in_take     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    pgs_isqrt #(
        .RW(RW)
    ) u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (root_start),
        .i_radicand(radicand),
        .o_done    (root_done),
        .o_root    (root)
    );

    pgs_udiv #(
        .NW(PW),
        .DW(DW),
        .QW(CW)
    ) u_udiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_dist),
        .o_done (div_done),
        .o_quo  (quo)
    );

    // Sequencer, pursuit state and configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_radius     <= RST_RADIUS;
            r_step       <= RST_STEP;
            r_tick_limit <= RST_TICK_LIMIT;
            r_pos_x      <= '0;
            r_pos_y      <= RST_START_Y;
            r_tick       <= '0;
            r_finished   <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            // A configuration transaction; start positions load the pursuer
            // until the first tick has been taken and have no effect after that.
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CAPTURE_RADIUS: r_radius <= i_cfg_data[LW-1:0];
                    REG_STEP_LENGTH:    r_step   <= i_cfg_data[LW-1:0];
                    REG_START_X: begin
                        if (fresh) begin
                            r_pos_x <= i_cfg_data;
                        end
                    end
                    REG_START_Y: begin
                        if (fresh) begin
                            r_pos_y <= i_cfg_data;
                        end
                    end
                    REG_TICK_LIMIT:     r_tick_limit <= i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_dx        <= {i_target_x[CW-1], i_target_x} -
                                       {r_pos_x[CW-1], r_pos_x};
                        r_dy        <= {i_target_y[CW-1], i_target_y} -
                                       {r_pos_y[CW-1], r_pos_y};
                        r_caught    <= 1'b0;
                        r_escaped   <= 1'b0;
                        r_done_item <= r_finished;
                        r_state     <= r_finished ? ST_OUT : ST_SQX;
                    end
                end
                ST_SQX: begin
                    r_prod  <= mul_p;
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_acc   <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= ST_RSTART;
                end
                ST_RSTART: begin
                    r_state <= ST_RWAIT;
                end
                ST_RWAIT: begin
                    if (root_done) begin
                        r_dist  <= dist_now;
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    // Capture ends the pursuit without a move.
                    if (r_dist <= {2'b00, r_radius}) begin
                        r_caught <= 1'b1;
                        r_state  <= ST_OUT;
                    end else begin
                        r_prod  <= mul_p;
                        r_state <= ST_DXSTART;
                    end
                end
                ST_DXSTART: begin
                    r_state <= ST_DXWAIT;
                end
                ST_DXWAIT: begin
                    if (div_done) begin
                        r_pos_x <= move_sat(r_pos_x, r_dx[CW], quo);
                        r_prod  <= mul_p;
                        r_state <= ST_DYSTART;
                    end
                end
                ST_DYSTART: begin
                    r_state <= ST_DYWAIT;
                end
                ST_DYWAIT: begin
                    if (div_done) begin
                        r_pos_y   <= move_sat(r_pos_y, r_dy[CW], quo);
                        r_escaped <= (idx_next >= {1'b0, lim});
                        r_state   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Hand the result to the output register once it is free.
                    if (out_free) begin
                        r_ovalid      <= 1'b1;
                        r_out_x       <= r_pos_x;
                        r_out_y       <= r_pos_y;
                        r_out_caught  <= r_caught;
                        r_out_escaped <= r_escaped;
                        r_out_done    <= r_done_item;
                        if (r_done_item) begin
                            r_out_sep <= '0;
                            r_out_idx <= (r_tick == '0) ? '0 : (r_tick - 1'b1);
                        end else begin
                            r_out_sep  <= sep_now;
                            r_out_idx  <= r_tick;
                            r_finished <= r_caught || r_escaped;
                            if (r_tick != TICK_MAX) begin
                                r_tick <= idx_next[TICK_W-1:0];
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_pursuer_x  = r_out_x;
    assign o_pursuer_y  = r_out_y;
    assign o_separation = r_out_sep;
    assign o_tick_index = r_out_idx;
    assign o_caught     = r_out_caught;
    assign o_escaped    = r_out_escaped;
    assign o_done_res   = r_out_done;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import pgs_pkg::*;

    localparam int CW   = 24;
    localparam int FRAC = 8;

    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint LMAX = CMAX;
    localparam longint unsigned SEP_MAX = (64'd1 << CW) - 1;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

    // Allow for the worst gaps, stalls and hold-off.
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 54;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic signed [CW-1:0] pursuer_x;
        logic signed [CW-1:0] pursuer_y;
        logic [CW-1:0]        separation;
        logic [TICK_W-1:0]    tick_index;
        logic                 caught;
        logic                 escaped;
        logic                 done_res;
    } tick_report_t;

    // Tracks the pursuit one tick ahead of the block and holds the reports still due.
    class pursuit_tracker;
        longint unsigned radius;
        longint unsigned step_len;
        longint unsigned limit;
        longint          start_x;
        longint          start_y;
        longint          pos_x;
        longint          pos_y;
        int              ticks;
        bit              finished;
        tick_report_t    pending_ticks[$];
        int              errors;
        int              checked;

        function new();
            radius   = longint'(RST_RADIUS_UNITS) << FRAC;
            step_len = longint'(RST_STEP_UNITS) << FRAC;
            limit    = RST_TICK_LIMIT;
            start_x  = 0;
            start_y  = longint'(RST_START_Y_UNITS) << FRAC;
            pos_x    = start_x;
            pos_y    = start_y;
            ticks    = 0;
            finished = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        static function longint clamp_coord(longint v);
            if (v > CMAX) return CMAX;
            if (v < CMIN) return CMIN;
            return v;
        endfunction

        // Floor of the square root, one result bit at a time.
        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 26; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        // Unsaturated distance from the pursuer to a target.
        function longint unsigned range_to(coord_t tx, coord_t ty);
            longint          dx;
            longint          dy;
            longint unsigned ax;
            longint unsigned ay;
            dx = longint'(tx) - pos_x;
            dy = longint'(ty) - pos_y;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            return root_floor(ax * ax + ay * ay);
        endfunction

        function bit would_catch(coord_t tx, coord_t ty);
            return !finished && (range_to(tx, ty) <= radius);
        endfunction

        // The opposite corner is always farther than the largest radius.
        function void far_corner(output coord_t tx, output coord_t ty);
            tx = coord_t'((pos_x >= 0) ? CMIN : CMAX);
            ty = coord_t'((pos_y >= 0) ? CMIN : CMAX);
        endfunction

        // One axis of the move: rounded step share, ties away from zero, then saturate.
        function longint step_axis(longint p, longint d, longint unsigned span);
            longint unsigned mag;
            longint unsigned q;
            mag = (d < 0) ? -d : d;
            q   = (step_len * mag + span / 2) / span;
            return clamp_coord((d < 0) ? p - longint'(q) : p + longint'(q));
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
            bit fresh;
            fresh = (ticks == 0) && !finished;
            case (idx)
                REG_CAPTURE_RADIUS: radius = data[CW-2:0];
                REG_STEP_LENGTH:    step_len = data[CW-2:0];
                REG_START_X: begin
                    start_x = coord_t'(data);
                    if (fresh) pos_x = start_x;
                end
                REG_START_Y: begin
                    start_y = coord_t'(data);
                    if (fresh) pos_y = start_y;
                end
                REG_TICK_LIMIT:     limit = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the pursuit by one accepted target and queue the report it causes.
        function void track_target(coord_t tx, coord_t ty);
            tick_report_t    r;
            longint          dx;
            longint          dy;
            longint unsigned span;
            longint unsigned lim;
            r = '0;
            r.done_res = finished;
            if (finished) begin
                r.tick_index = (ticks != 0) ? TICK_W'(ticks - 1) : '0;
            end else begin
                dx   = longint'(tx) - pos_x;
                dy   = longint'(ty) - pos_y;
                span = range_to(tx, ty);
                lim  = (limit == 0) ? 1 : limit;
                r.separation = (span > SEP_MAX) ? '1 : span[CW-1:0];
                r.tick_index = TICK_W'(ticks);
                if (span <= radius) begin
                    r.caught = 1'b1;
                    finished = 1'b1;
                end else begin
                    pos_x = step_axis(pos_x, dx, span);
                    pos_y = step_axis(pos_y, dy, span);
                    // The last allowed tick still moves, then flags the escape.
                    if (longint'(ticks) + 1 >= longint'(lim)) begin
                        r.escaped = 1'b1;
                        finished  = 1'b1;
                    end
                end
                if (ticks < int'(TICK_MAX)) ticks++;
            end
            r.pursuer_x = coord_t'(pos_x);
            r.pursuer_y = coord_t'(pos_y);
            pending_ticks.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 40) $display("tb: result %0d: %s", checked, what);
        endtask

        task check_result(tick_report_t got);
            tick_report_t want;
            checked++;
            if (pending_ticks.size() == 0) begin
                report_mismatch("report arrived with nothing outstanding");
                return;
            end
            want = pending_ticks.pop_front();
            if (got.pursuer_x !== want.pursuer_x)
                report_mismatch($sformatf("pursuer_x %0d, expected %0d",
                                          got.pursuer_x, want.pursuer_x));
            if (got.pursuer_y !== want.pursuer_y)
                report_mismatch($sformatf("pursuer_y %0d, expected %0d",
                                          got.pursuer_y, want.pursuer_y));
            if (got.separation !== want.separation)
                report_mismatch($sformatf("separation %0d, expected %0d",
                                          got.separation, want.separation));
            if (got.tick_index !== want.tick_index)
                report_mismatch($sformatf("tick_index %0d, expected %0d",
                                          got.tick_index, want.tick_index));
            if (got.caught !== want.caught)
                report_mismatch($sformatf("caught %b, expected %b", got.caught, want.caught));
            if (got.escaped !== want.escaped)
                report_mismatch($sformatf("escaped %b, expected %b",
                                          got.escaped, want.escaped));
            if (got.done_res !== want.done_res)
                report_mismatch($sformatf("done_res %b, expected %b",
                                          got.done_res, want.done_res));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CW-1:0]        i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    coord_t               i_target_x;
    coord_t               i_target_y;
    logic                 o_out_valid;
    logic                 i_out_ready;
    coord_t               o_pursuer_x;
    coord_t               o_pursuer_y;
    logic [CW-1:0]        o_separation;
    logic [TICK_W-1:0]    o_tick_index;
    logic                 o_caught;
    logic                 o_escaped;
    logic                 o_done_res;

    pursuit_tracker tracker;
    bit             rush;
    bit             hold_results;
    int             targets_sent;
    int             reg_writes;
    int             cycle_count;

    pursuit_guidance_step #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FRAC)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pursuer_x  (o_pursuer_x),
        .o_pursuer_y  (o_pursuer_y),
        .o_separation (o_separation),
        .o_tick_index (o_tick_index),
        .o_caught     (o_caught),
        .o_escaped    (o_escaped),
        .o_done_res   (o_done_res)
    );

    // Free-running 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one target and hold it until the block takes the transaction.
    task automatic send_target(input coord_t tx, input coord_t ty);
        int gap;
        i_in_valid <= 1'b1;
        i_target_x <= tx;
        i_target_y <= ty;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.track_target(tx, ty);
        targets_sent++;
        gap = rush ? 0 : $urandom_range(14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Target for a live tick, replaced by a far one if it would be a capture.
    task automatic send_clear(input coord_t tx, input coord_t ty);
        coord_t cx;
        coord_t cy;
        cx = tx;
        cy = ty;
        if (tracker.would_catch(cx, cy)) tracker.far_corner(cx, cy);
        send_target(cx, cy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.apply_reg(idx, data);
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering and wait until every queued report has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.pending_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic coord_t pick_extreme(longint p);
        case ($urandom_range(4))
            0:       return coord_t'(CMIN);
            1:       return coord_t'(CMAX);
            2:       return '0;
            3:       return '1;
            default: return coord_t'(p);
        endcase
    endfunction

    // Length register value with a random unused top bit.
    function automatic logic [CW-1:0] pick_length();
        longint len;
        case ($urandom_range(4))
            0:       len = 0;
            1:       len = LMAX;
            2:       len = $urandom_range(16, 1);
            3:       len = $urandom_range(65535, 256);
            default: len = $urandom_range(32'(LMAX), 0);
        endcase
        return {1'($urandom_range(1)), (CW-1)'(len)};
    endfunction

    function automatic logic [CW-1:0] limit_word(int lim);
        return {(CW-TICK_W)'($urandom()), TICK_W'(lim)};
    endfunction

    // Random target for a live tick: wide, near, on an axis, at the extremes, or just
    // outside the capture radius.
    function automatic void pick_target(output coord_t tx, output coord_t ty);
        longint reach;
        longint off;
        reach = longint'(tracker.radius) + 2 * longint'(tracker.step_len) + 512;
        for (int tries = 0; tries < 8; tries++) begin
            case ($urandom_range(4))
                0: begin
                    tx = coord_t'($urandom());
                    ty = coord_t'($urandom());
                end
                1: begin
                    tx = coord_t'(pursuit_tracker::clamp_coord(tracker.pos_x
                             + longint'($urandom_range(32'(2 * reach))) - reach));
                    ty = coord_t'(pursuit_tracker::clamp_coord(tracker.pos_y
                             + longint'($urandom_range(32'(2 * reach))) - reach));
                end
                2: begin
                    if ($urandom_range(1) == 1) begin
                        tx = coord_t'(tracker.pos_x);
                        ty = coord_t'($urandom());
                    end else begin
                        tx = coord_t'($urandom());
                        ty = coord_t'(tracker.pos_y);
                    end
                end
                3: begin
                    tx = pick_extreme(tracker.pos_x);
                    ty = pick_extreme(tracker.pos_y);
                end
                default: begin
                    off = longint'(tracker.radius) + 1 + longint'($urandom_range(2));
                    if ($urandom_range(1) == 1) off = -off;
                    tx = coord_t'(tracker.pos_x);
                    ty = coord_t'(tracker.pos_y);
                    if ($urandom_range(1) == 1)
                        tx = coord_t'(pursuit_tracker::clamp_coord(tracker.pos_x + off));
                    else
                        ty = coord_t'(pursuit_tracker::clamp_coord(tracker.pos_y + off));
                end
            endcase
            if (!tracker.would_catch(tx, ty)) return;
        end
        tracker.far_corner(tx, ty);
    endfunction

    // Result side: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int           stall;
        tick_report_t got;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                stall = 700;
            end else begin
                stall = ((tracker.checked / 40) % 3 == 1) ? 0 : $urandom_range(14);
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got = {o_pursuer_x, o_pursuer_y, o_separation, o_tick_index,
                   o_caught, o_escaped, o_done_res};
            tracker.check_result(got);
        end
    end

    // Stimulus: directed ticks, random phases, then the end of the pursuit.
    initial begin
        coord_t tx;
        coord_t ty;
        int     ending;
        string  ending_name;

        tracker      = new();
        rush         = 1'b0;
        hold_results = 1'b0;
        targets_sent = 0;
        reg_writes   = 0;
        cycle_count  = 0;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_target_x  <= '0;
        i_target_y  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before the first tick a start write also moves the pursuer; y keeps its default.
        write_reg(REG_START_X, CW'(CMIN));

        // Default radius and step: saturating separation, then just outside capture.
        send_clear(coord_t'(CMAX), coord_t'(CMIN));
        send_clear(coord_t'(pursuit_tracker::clamp_coord(tracker.pos_x
                       + longint'(tracker.radius) + 1)), coord_t'(tracker.pos_y));
        send_clear(coord_t'(tracker.pos_x), coord_t'(pursuit_tracker::clamp_coord(
                       tracker.pos_y - longint'(tracker.radius) - 1)));

        // Largest step with zero radius: overshoot and saturation at the corners.
        // The start write now only changes the register; unused indexes are ignored.
        drain_results();
        write_reg(REG_TICK_LIMIT, limit_word(int'(TICK_MAX)));
        write_reg(REG_CAPTURE_RADIUS, '0);
        write_reg(REG_STEP_LENGTH, CW'(LMAX));
        write_reg(REG_START_Y, CW'(CMAX));
        write_reg(REG_UNUSED_FIRST, CW'($urandom()));
        write_reg(REG_UNUSED_LAST, CW'($urandom()));
        send_clear(coord_t'(pursuit_tracker::clamp_coord(tracker.pos_x + 1)),
                   coord_t'(tracker.pos_y));
        send_clear(coord_t'(CMAX), coord_t'(CMAX));
        send_clear(coord_t'(CMIN), coord_t'(CMAX));
        send_clear(coord_t'(CMIN), coord_t'(CMIN));
        send_clear(coord_t'(CMAX), coord_t'(CMIN));

        // Zero step with the largest radius: the pursuer stays put.
        drain_results();
        write_reg(REG_STEP_LENGTH, '0);
        write_reg(REG_CAPTURE_RADIUS, CW'(LMAX));
        tracker.far_corner(tx, ty);
        send_clear(tx, ty);
        send_clear(coord_t'($urandom()), coord_t'($urandom()));

        // Unit step: rounding of half a unit, both signs.
        drain_results();
        write_reg(REG_CAPTURE_RADIUS, '0);
        write_reg(REG_STEP_LENGTH, CW'(1));
        send_clear(coord_t'(pursuit_tracker::clamp_coord(tracker.pos_x + 1)),
                   coord_t'(pursuit_tracker::clamp_coord(tracker.pos_y + 2)));
        send_clear(coord_t'(pursuit_tracker::clamp_coord(tracker.pos_x - 1)),
                   coord_t'(pursuit_tracker::clamp_coord(tracker.pos_y - 2)));
        send_clear(coord_t'(pursuit_tracker::clamp_coord(tracker.pos_x - 3)),
                   coord_t'(pursuit_tracker::clamp_coord(tracker.pos_y + 4)));

        // Random phases, each with its own radius, step and tick limit.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            write_reg(REG_CAPTURE_RADIUS, (phase == 1) ? CW'(LMAX) :
                                          (phase == 2) ? '0 : pick_length());
            write_reg(REG_STEP_LENGTH, (phase == 1) ? CW'(LMAX) :
                                       (phase == 2) ? '0 : pick_length());
            if ($urandom_range(1) == 1) write_reg(REG_START_X, CW'($urandom()));
            if ($urandom_range(1) == 1) write_reg(REG_START_Y, CW'($urandom()));
            write_reg(REG_TICK_LIMIT, limit_word((phase == 0) ? int'(TICK_MAX) :
                          int'($urandom_range(int'(TICK_MAX), tracker.ticks + 600))));
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(2)),
                          CW'($urandom()));
            rush = ($urandom_range(3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == PHASE_ITEMS / 2) drain_results();
                if (phase == 5 && n == 10) hold_results = 1'b1;
                pick_target(tx, ty);
                send_target(tx, ty);
            end
        end

        // End the pursuit: a zero or unit limit, escape on the next tick, or a capture
        // exactly at the radius on the last allowed tick.
        drain_results();
        rush = 1'b0;
        ending = $urandom_range(2);
        if (ending == 0) write_reg(REG_TICK_LIMIT, limit_word($urandom_range(1)));
        else             write_reg(REG_TICK_LIMIT, limit_word(tracker.ticks + 1));
        if (ending == 2) begin
            ending_name = "capture on the last allowed tick";
            ty = coord_t'(tracker.pos_y);
            if (tracker.pos_x + longint'(tracker.radius) <= CMAX)
                tx = coord_t'(tracker.pos_x + longint'(tracker.radius));
            else
                tx = coord_t'(tracker.pos_x - longint'(tracker.radius));
        end else begin
            ending_name = (ending == 0) ? "escape under a zero or unit limit"
                                        : "escape on the last allowed tick";
            tracker.far_corner(tx, ty);
        end
        send_target(tx, ty);

        // Targets after the end leave everything as it is.
        for (int n = 0; n < 8; n++) send_target(coord_t'($urandom()), coord_t'($urandom()));
        drain_results();
        write_reg(REG_START_X, CW'($urandom()));
        for (int n = 0; n < 2; n++) send_target(coord_t'($urandom()), coord_t'($urandom()));

        drain_results();
        repeat (100) @(posedge i_clk);
        if (tracker.pending_ticks.size() != 0)
            tracker.report_mismatch($sformatf("%0d reports never arrived",
                                              tracker.pending_ticks.size()));
        $display("tb: %0d targets sent, %0d reports checked, %0d register writes",
                 targets_sent, tracker.checked, reg_writes);
        $display("tb: pursuit ended by %s after %0d ticks, %0d mismatches",
                 ending_name, tracker.ticks, tracker.errors);
        if (tracker.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/pgs_pkg.sv
src/pgs_isqrt.sv
src/pgs_udiv.sv
src/pursuit_guidance_step.sv
sim/tb.sv
